// ===== rtl/lsi_pkg.sv =====
package lsi_pkg;

   // coordinate width; the fraction bits cancel in the quotient and set no width here
   localparam int COORD_WIDTH = 16;

   // derived widths
   localparam int CW   = COORD_WIDTH;
   localparam int DW   = CW + 1;        // coordinate difference
   localparam int PW   = 2 * DW;        // product of two differences
   localparam int DETW = PW + 1;        // determinant
   localparam int CPW  = 2 * CW;        // product of two coordinates
   localparam int PREW = CPW + 1;       // pre and post cross terms
   localparam int NPW  = PREW + DW;     // cross term times difference
   localparam int NW   = NPW + 1;       // numerator
   localparam int MW   = NW + 1;        // sign-normalized numerator
   localparam int RPW  = CW + DETW + 1; // bound times determinant
   localparam int QW   = 32;            // result coordinate
   localparam int OVW  = DETW + QW;     // quotient overflow compare

   // coordinate slots of one item
   localparam int X1 = 0;
   localparam int Y1 = 1;
   localparam int X2 = 2;
   localparam int Y2 = 3;
   localparam int X3 = 4;
   localparam int Y3 = 5;
   localparam int X4 = 6;
   localparam int Y4 = 7;

   // bounding range axes
   localparam int AX_X12 = 0;
   localparam int AX_Y12 = 1;
   localparam int AX_X34 = 2;
   localparam int AX_Y34 = 3;

   // request modes
   localparam logic [1:0] MODE_LINE     = 2'd0;
   localparam logic [1:0] MODE_SEG      = 2'd1;
   localparam logic [1:0] MODE_SEG_LINE = 2'd2;

   localparam logic [QW-1:0] POS_MAX = {1'b0, {(QW-1){1'b1}}};
   localparam logic [QW-1:0] NEG_MIN = {1'b1, {(QW-1){1'b0}}};

   typedef struct packed {
      logic [1:0]          mode;
      logic [7:0][CW-1:0]  c;
   } pts_type;

   typedef struct packed {
      logic [1:0]          mode;
      logic                par;
      logic [DETW-1:0]     d;
      logic [MW-1:0]       nx;
      logic [MW-1:0]       ny;
      logic [3:0][CW-1:0]  lo;
      logic [3:0][CW-1:0]  hi;
   } front_type;

   typedef struct packed {
      logic            par;
      logic            hit;
      logic            negx;
      logic            negy;
      logic            ovx;
      logic            ovy;
      logic [DETW-1:0] d;
      logic [MW-1:0]   mx;
      logic [MW-1:0]   my;
   } div_in_type;

   typedef struct packed {
      logic          par;
      logic          hit;
      logic          negx;
      logic          negy;
      logic          ovx;
      logic          ovy;
      logic [QW-1:0] qx;
      logic [QW-1:0] qy;
   } div_out_type;

endpackage

// ===== rtl/line_segment_intersection.sv =====
// Intersection of two lines or segments, P1-P2 against P3-P4.
// Input channel: req_valid / req_stall with req_type (0 line vs line,
// 1 segment vs segment, 2 first segment vs second line, 3 as 0) and the
// four points in signed fixed point. Result channel: rsp_valid / rsp_stall
// with hit, is_parallel, cross_x, cross_y (32 bit, same fraction bits as the
// inputs, truncated toward zero, saturated) and clipped.
// An item is taken at any edge where valid is high and stall is low.
// From input item to result item an item passes five stages of products
// and sums, two stages of range test, 32 divider stages (one quotient bit
// each) and the output register. Throughput is one item per cycle unless
// a held result stalls; the divider pipeline sets the depth.
// A parallel pair gives hit 0, is_parallel 1 and zero coordinates.
// Reset empties the pipeline; the first item can enter in the cycle after.
// While a result waits under rsp_stall the whole pipeline holds and
// req_stall is raised; nothing is lost or repeated.
module line_segment_intersection (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_type,
   input  logic signed [lsi_pkg::CW-1:0] req_first_start_x,
   input  logic signed [lsi_pkg::CW-1:0] req_first_start_y,
   input  logic signed [lsi_pkg::CW-1:0] req_first_end_x,
   input  logic signed [lsi_pkg::CW-1:0] req_first_end_y,
   input  logic signed [lsi_pkg::CW-1:0] req_second_start_x,
   input  logic signed [lsi_pkg::CW-1:0] req_second_start_y,
   input  logic signed [lsi_pkg::CW-1:0] req_second_end_x,
   input  logic signed [lsi_pkg::CW-1:0] req_second_end_y,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_hit,
   output logic                          rsp_is_parallel,
   output logic signed [lsi_pkg::QW-1:0] rsp_cross_x,
   output logic signed [lsi_pkg::QW-1:0] rsp_cross_y,
   output logic                          rsp_clipped
);
   import lsi_pkg::*;

   logic        adv;
   pts_type     pts;
   logic        f_valid;
   front_type   f_data;
   logic        d_valid;
   div_in_type  d_data;
   logic        q_valid;
   div_out_type q_data;

   // pipeline moves when the output register is free or drains
   assign adv       = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;

   assign pts.mode  = req_type;
   assign pts.c[X1] = req_first_start_x;
   assign pts.c[Y1] = req_first_start_y;
   assign pts.c[X2] = req_first_end_x;
   assign pts.c[Y2] = req_first_end_y;
   assign pts.c[X3] = req_second_start_x;
   assign pts.c[Y3] = req_second_start_y;
   assign pts.c[X4] = req_second_end_x;
   assign pts.c[Y4] = req_second_end_y;

   lsi_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .in_pts    (pts),
      .out_valid (f_valid),
      .out_f     (f_data)
   );

   lsi_range u_range (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (f_valid),
      .in_f      (f_data),
      .out_valid (d_valid),
      .out_d     (d_data)
   );

   lsi_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (d_valid),
      .in_d      (d_data),
      .out_valid (q_valid),
      .out_q     (q_data)
   );

   // sign and saturation of the quotients
   logic          clip_x, clip_y;
   logic [QW-1:0] vx, vy;

   always_comb begin
      if (q_data.negx) begin
         clip_x = q_data.ovx || (q_data.qx > NEG_MIN);
         vx     = clip_x ? NEG_MIN : QW'(-q_data.qx);
      end else begin
         clip_x = q_data.ovx || (q_data.qx > POS_MAX);
         vx     = clip_x ? POS_MAX : q_data.qx;
      end
      if (q_data.negy) begin
         clip_y = q_data.ovy || (q_data.qy > NEG_MIN);
         vy     = clip_y ? NEG_MIN : QW'(-q_data.qy);
      end else begin
         clip_y = q_data.ovy || (q_data.qy > POS_MAX);
         vy     = clip_y ? POS_MAX : q_data.qy;
      end
      if (q_data.par) begin
         clip_x = 1'b0;
         clip_y = 1'b0;
         vx     = '0;
         vy     = '0;
      end
   end

   // output register
   logic          rsp_valid_ff;
   logic          hit_ff, par_ff, clip_ff;
   logic [QW-1:0] cx_ff, cy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= q_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         hit_ff  <= q_data.hit;
         par_ff  <= q_data.par;
         clip_ff <= clip_x || clip_y;
         cx_ff   <= vx;
         cy_ff   <= vy;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = hit_ff;
   assign rsp_is_parallel = par_ff;
   assign rsp_clipped     = clip_ff;
   assign rsp_cross_x     = $signed(cx_ff);
   assign rsp_cross_y     = $signed(cy_ff);

   // parallel item carries no point
   a_parallel_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_parallel |->
         !rsp_hit && !rsp_clipped && rsp_cross_x == 0 && rsp_cross_y == 0)
      else $error("parallel item with nonzero result");

   // clipped result sits at a range limit
   a_clip_limit : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_clipped |->
         rsp_cross_x == $signed(POS_MAX) || rsp_cross_x == $signed(NEG_MIN) ||
         rsp_cross_y == $signed(POS_MAX) || rsp_cross_y == $signed(NEG_MIN))
      else $error("clipped item not at a limit");

   // input stalls only behind a held result
   a_stall_source : assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("input stall without held result");

   // held result keeps its point
   a_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_cross_x) &&
         $stable(rsp_cross_y) && $stable(rsp_hit))
      else $error("held result changed");

endmodule

// ===== rtl/lsi_front.sv =====
module lsi_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  lsi_pkg::pts_type   in_pts,
   output logic               out_valid,
   output lsi_pkg::front_type out_f
);
   import lsi_pkg::*;

   logic signed [CW-1:0] x1, y1, x2, y2, x3, y3, x4, y4;
   logic signed [DW-1:0] dx12, dy12, dx34, dy34;
   logic [3:0][CW-1:0]   lo, hi;

   assign x1 = $signed(in_pts.c[X1]);
   assign y1 = $signed(in_pts.c[Y1]);
   assign x2 = $signed(in_pts.c[X2]);
   assign y2 = $signed(in_pts.c[Y2]);
   assign x3 = $signed(in_pts.c[X3]);
   assign y3 = $signed(in_pts.c[Y3]);
   assign x4 = $signed(in_pts.c[X4]);
   assign y4 = $signed(in_pts.c[Y4]);

   assign dx12 = DW'(x1) - DW'(x2);
   assign dy12 = DW'(y1) - DW'(y2);
   assign dx34 = DW'(x3) - DW'(x4);
   assign dy34 = DW'(y3) - DW'(y4);

   // bounding ranges of both pairs
   always_comb begin
      lo[AX_X12] = (x1 < x2) ? x1 : x2;
      hi[AX_X12] = (x1 < x2) ? x2 : x1;
      lo[AX_Y12] = (y1 < y2) ? y1 : y2;
      hi[AX_Y12] = (y1 < y2) ? y2 : y1;
      lo[AX_X34] = (x3 < x4) ? x3 : x4;
      hi[AX_X34] = (x3 < x4) ? x4 : x3;
      lo[AX_Y34] = (y3 < y4) ? y3 : y4;
      hi[AX_Y34] = (y3 < y4) ? y4 : y3;
   end

   // stage 1: first products
   logic                  s1_vld_ff;
   logic [1:0]            s1_mode_ff;
   logic signed [PW-1:0]  s1_pa_ff, s1_pb_ff;
   logic signed [CPW-1:0] s1_pc_ff, s1_pd_ff, s1_pe_ff, s1_pf_ff;
   logic signed [DW-1:0]  s1_dx12_ff, s1_dy12_ff, s1_dx34_ff, s1_dy34_ff;
   logic [3:0][CW-1:0]    s1_lo_ff, s1_hi_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_mode_ff <= in_pts.mode;
         s1_pa_ff   <= dx12 * dy34;
         s1_pb_ff   <= dy12 * dx34;
         s1_pc_ff   <= x1 * y2;
         s1_pd_ff   <= y1 * x2;
         s1_pe_ff   <= x3 * y4;
         s1_pf_ff   <= y3 * x4;
         s1_dx12_ff <= dx12;
         s1_dy12_ff <= dy12;
         s1_dx34_ff <= dx34;
         s1_dy34_ff <= dy34;
         s1_lo_ff   <= lo;
         s1_hi_ff   <= hi;
      end
   end

   // stage 2: determinant and cross terms
   logic                   s2_vld_ff;
   logic [1:0]             s2_mode_ff;
   logic signed [DETW-1:0] s2_d_ff;
   logic signed [PREW-1:0] s2_pre_ff, s2_post_ff;
   logic signed [DW-1:0]   s2_dx12_ff, s2_dy12_ff, s2_dx34_ff, s2_dy34_ff;
   logic [3:0][CW-1:0]     s2_lo_ff, s2_hi_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (adv) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_mode_ff <= s1_mode_ff;
         s2_d_ff    <= DETW'(s1_pa_ff) - DETW'(s1_pb_ff);
         s2_pre_ff  <= PREW'(s1_pc_ff) - PREW'(s1_pd_ff);
         s2_post_ff <= PREW'(s1_pe_ff) - PREW'(s1_pf_ff);
         s2_dx12_ff <= s1_dx12_ff;
         s2_dy12_ff <= s1_dy12_ff;
         s2_dx34_ff <= s1_dx34_ff;
         s2_dy34_ff <= s1_dy34_ff;
         s2_lo_ff   <= s1_lo_ff;
         s2_hi_ff   <= s1_hi_ff;
      end
   end

   // stage 3: numerator products
   logic                   s3_vld_ff;
   logic [1:0]             s3_mode_ff;
   logic signed [DETW-1:0] s3_d_ff;
   logic signed [NPW-1:0]  s3_a_ff, s3_b_ff, s3_c_ff, s3_e_ff;
   logic [3:0][CW-1:0]     s3_lo_ff, s3_hi_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (adv) begin
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_mode_ff <= s2_mode_ff;
         s3_d_ff    <= s2_d_ff;
         s3_a_ff    <= s2_pre_ff * s2_dx34_ff;
         s3_b_ff    <= s2_dx12_ff * s2_post_ff;
         s3_c_ff    <= s2_pre_ff * s2_dy34_ff;
         s3_e_ff    <= s2_dy12_ff * s2_post_ff;
         s3_lo_ff   <= s2_lo_ff;
         s3_hi_ff   <= s2_hi_ff;
      end
   end

   // stage 4: numerators and parallel check
   logic                   s4_vld_ff;
   logic [1:0]             s4_mode_ff;
   logic                   s4_par_ff;
   logic signed [DETW-1:0] s4_d_ff;
   logic signed [NW-1:0]   s4_nx_ff, s4_ny_ff;
   logic [3:0][CW-1:0]     s4_lo_ff, s4_hi_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else if (adv) begin
         s4_vld_ff <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_mode_ff <= s3_mode_ff;
         s4_par_ff  <= (s3_d_ff == '0);
         s4_d_ff    <= s3_d_ff;
         s4_nx_ff   <= NW'(s3_a_ff) - NW'(s3_b_ff);
         s4_ny_ff   <= NW'(s3_c_ff) - NW'(s3_e_ff);
         s4_lo_ff   <= s3_lo_ff;
         s4_hi_ff   <= s3_hi_ff;
      end
   end

   // stage 5: make the determinant positive
   logic                 neg;
   logic signed [MW-1:0] nxe, nye;
   front_type            f_in;
   front_type            f_ff;
   logic                 f_vld_ff;

   assign neg = s4_d_ff[DETW-1];
   assign nxe = MW'(s4_nx_ff);
   assign nye = MW'(s4_ny_ff);

   always_comb begin
      f_in.mode = s4_mode_ff;
      f_in.par  = s4_par_ff;
      f_in.d    = neg ? DETW'(-s4_d_ff) : DETW'(s4_d_ff);
      f_in.nx   = neg ? MW'(-nxe) : MW'(nxe);
      f_in.ny   = neg ? MW'(-nye) : MW'(nye);
      f_in.lo   = s4_lo_ff;
      f_in.hi   = s4_hi_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_vld_ff <= 1'b0;
      end else if (adv) begin
         f_vld_ff <= s4_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f_ff <= f_in;
      end
   end

   assign out_valid = f_vld_ff;
   assign out_f     = f_ff;

endmodule

// ===== rtl/lsi_range.sv =====
module lsi_range (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_valid,
   input  lsi_pkg::front_type  in_f,
   output logic                out_valid,
   output lsi_pkg::div_in_type out_d
);
   import lsi_pkg::*;

   logic signed [DETW:0]  ds;
   logic signed [MW-1:0]  nxs, nys;

   assign ds  = $signed({1'b0, in_f.d});
   assign nxs = $signed(in_f.nx);
   assign nys = $signed(in_f.ny);

   // stage 1: bounds scaled by the determinant, numerator magnitudes
   logic                  r1_vld_ff;
   front_type             r1_f_ff;
   logic signed [RPW-1:0] r1_lop_ff [4];
   logic signed [RPW-1:0] r1_hip_ff [4];
   logic [MW-1:0]         r1_mx_ff, r1_my_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         r1_vld_ff <= 1'b0;
      end else if (adv) begin
         r1_vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         r1_f_ff  <= in_f;
         r1_mx_ff <= nxs[MW-1] ? MW'(-nxs) : MW'(nxs);
         r1_my_ff <= nys[MW-1] ? MW'(-nys) : MW'(nys);
         for (int k = 0; k < 4; k++) begin
            r1_lop_ff[k] <= $signed(in_f.lo[k]) * ds;
            r1_hip_ff[k] <= $signed(in_f.hi[k]) * ds;
         end
      end
   end

   // stage 2: containment, hit and quotient overflow
   logic signed [RPW-1:0] nxr, nyr;
   logic [3:0]            inr;
   logic                  hit;
   div_in_type            d_in;
   div_in_type            d_ff;
   logic                  d_vld_ff;

   assign nxr = RPW'($signed(r1_f_ff.nx));
   assign nyr = RPW'($signed(r1_f_ff.ny));

   always_comb begin
      inr[AX_X12] = (r1_lop_ff[AX_X12] <= nxr) && (nxr <= r1_hip_ff[AX_X12]);
      inr[AX_Y12] = (r1_lop_ff[AX_Y12] <= nyr) && (nyr <= r1_hip_ff[AX_Y12]);
      inr[AX_X34] = (r1_lop_ff[AX_X34] <= nxr) && (nxr <= r1_hip_ff[AX_X34]);
      inr[AX_Y34] = (r1_lop_ff[AX_Y34] <= nyr) && (nyr <= r1_hip_ff[AX_Y34]);
      case (r1_f_ff.mode)
         MODE_SEG:      hit = &inr;
         MODE_SEG_LINE: hit = inr[AX_X12] && inr[AX_Y12];
         default:       hit = 1'b1;
      endcase
      d_in.par  = r1_f_ff.par;
      d_in.hit  = hit && !r1_f_ff.par;
      d_in.negx = r1_f_ff.nx[MW-1];
      d_in.negy = r1_f_ff.ny[MW-1];
      d_in.ovx  = OVW'(r1_mx_ff) >= (OVW'(r1_f_ff.d) << QW);
      d_in.ovy  = OVW'(r1_my_ff) >= (OVW'(r1_f_ff.d) << QW);
      d_in.d    = r1_f_ff.d;
      d_in.mx   = r1_mx_ff;
      d_in.my   = r1_my_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff <= 1'b0;
      end else if (adv) begin
         d_vld_ff <= r1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d_ff <= d_in;
      end
   end

   assign out_valid = d_vld_ff;
   assign out_d     = d_ff;

endmodule

// ===== rtl/lsi_div.sv =====
module lsi_div (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic                 in_valid,
   input  lsi_pkg::div_in_type  in_d,
   output logic                 out_valid,
   output lsi_pkg::div_out_type out_q
);
   import lsi_pkg::*;

   typedef struct packed {
      logic            par;
      logic            hit;
      logic            negx;
      logic            negy;
      logic            ovx;
      logic            ovy;
      logic [DETW-1:0] d;
      logic [MW-1:0]   rx;
      logic [MW-1:0]   ry;
      logic [QW-1:0]   qx;
      logic [QW-1:0]   qy;
   } stage_type;

   // one restoring step on both coordinates
   function automatic stage_type div_step(input stage_type a, input int sh);
      logic [OVW-1:0] dsh;
      stage_type      r;
      r   = a;
      dsh = OVW'(a.d) << sh;
      if (OVW'(a.rx) >= dsh) begin
         r.rx = a.rx - MW'(dsh);
         r.qx = a.qx | (QW'(1) << sh);
      end
      if (OVW'(a.ry) >= dsh) begin
         r.ry = a.ry - MW'(dsh);
         r.qy = a.qy | (QW'(1) << sh);
      end
      return r;
   endfunction

   stage_type stg_d  [QW];
   stage_type stg_ff [QW];
   logic      vld_d  [QW];
   logic      vld_ff [QW];

   // first stage takes the item from the range test
   assign stg_d[0].par  = in_d.par;
   assign stg_d[0].hit  = in_d.hit;
   assign stg_d[0].negx = in_d.negx;
   assign stg_d[0].negy = in_d.negy;
   assign stg_d[0].ovx  = in_d.ovx;
   assign stg_d[0].ovy  = in_d.ovy;
   assign stg_d[0].d    = in_d.d;
   assign stg_d[0].rx   = in_d.mx;
   assign stg_d[0].ry   = in_d.my;
   assign stg_d[0].qx   = '0;
   assign stg_d[0].qy   = '0;
   assign vld_d[0]      = in_valid;

   // one quotient bit per stage, most significant first
   for (genvar s = 0; s < QW; s++) begin : g_stage
      if (s > 0) begin : g_link
         assign stg_d[s] = stg_ff[s-1];
         assign vld_d[s] = vld_ff[s-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (adv) begin
            vld_ff[s] <= vld_d[s];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            stg_ff[s] <= div_step(stg_d[s], QW - 1 - s);
         end
      end
   end

   assign out_valid  = vld_ff[QW-1];
   assign out_q.par  = stg_ff[QW-1].par;
   assign out_q.hit  = stg_ff[QW-1].hit;
   assign out_q.negx = stg_ff[QW-1].negx;
   assign out_q.negy = stg_ff[QW-1].negy;
   assign out_q.ovx  = stg_ff[QW-1].ovx;
   assign out_q.ovy  = stg_ff[QW-1].ovy;
   assign out_q.qx   = stg_ff[QW-1].qx;
   assign out_q.qy   = stg_ff[QW-1].qy;

endmodule
